@@ src/r2y_pkg.sv @@
// Shared types and constants for the 2x2 RGB to YUV 4:2:0 converter.
// Holds the word structs, the fixed-point coefficients and the stage enable struct.
// No dependencies.
`timescale 1ns / 1ps

package r2y_pkg;

    // Number of pixels in one 2x2 block, one lane each.
    localparam int NUM_LANES = 4;

    // Fixed-point layout: coefficients carry 16 fraction bits.
    localparam int FRAC_W  = 16;
    localparam int COEF_W  = 16;
    // One product of an 8-bit channel and a 16-bit weight magnitude.
    localparam int PROD_W  = 24;
    // Luma sum of three products plus the rounding half.
    localparam int LUMA_W  = 25;
    // Signed chroma partial sums and the four-pixel total.
    localparam int PART_W  = 28;
    // Chroma total is divided by 4 * 65536.
    localparam int CHROMA_SHIFT = FRAC_W + 2;

    localparam int ROUND_HALF  = 32768;
    localparam int CHROMA_BIAS = 128 * 65536;

    // Weight magnitudes; the signs are applied in the lane adders.
    localparam logic [COEF_W-1:0] Y_R_COEF = 16'd19595;
    localparam logic [COEF_W-1:0] Y_G_COEF = 16'd38470;
    localparam logic [COEF_W-1:0] Y_B_COEF = 16'd7471;
    localparam logic [COEF_W-1:0] U_R_COEF = 16'd9634;   // negative
    localparam logic [COEF_W-1:0] U_G_COEF = 16'd18940;  // negative
    localparam logic [COEF_W-1:0] U_B_COEF = 16'd28574;
    localparam logic [COEF_W-1:0] V_R_COEF = 16'd40305;
    localparam logic [COEF_W-1:0] V_G_COEF = 16'd33751;  // negative
    localparam logic [COEF_W-1:0] V_B_COEF = 16'd6554;   // negative

    typedef logic [7:0]               sample_t;
    typedef logic signed [PART_W-1:0] chroma_part_t;

    typedef struct packed {
        sample_t red;
        sample_t green;
        sample_t blue;
    } rgb_t;

    typedef struct packed {
        sample_t tl_red;
        sample_t tl_green;
        sample_t tl_blue;
        sample_t tr_red;
        sample_t tr_green;
        sample_t tr_blue;
        sample_t bl_red;
        sample_t bl_green;
        sample_t bl_blue;
        sample_t br_red;
        sample_t br_green;
        sample_t br_blue;
    } pix_word_t;

    typedef struct packed {
        sample_t luma_tl;
        sample_t luma_tr;
        sample_t luma_bl;
        sample_t luma_br;
        sample_t chroma_u;
        sample_t chroma_v;
    } yuv_word_t;

    // Load enables for the two lane stages.
    typedef struct packed {
        logic s1;
        logic s2;
    } stage_en_t;

endpackage

@@ src/r2y_lane.sv @@
// One pixel lane of the converter: nine constant products, then luma and chroma partial sums.
// Uses r2y_pkg.
`timescale 1ns / 1ps

module r2y_lane (
    input  logic                  clk,
    input  r2y_pkg::stage_en_t    en,
    input  r2y_pkg::rgb_t         pixel,
    output r2y_pkg::sample_t      luma,
    output r2y_pkg::chroma_part_t u_part,
    output r2y_pkg::chroma_part_t v_part
);

    localparam int PW = r2y_pkg::PROD_W;
    localparam int LW = r2y_pkg::LUMA_W;
    localparam int CW = r2y_pkg::PART_W;

    logic [PW-1:0] yr_reg, yg_reg, yb_reg;
    logic [PW-1:0] ur_reg, ug_reg, ub_reg;
    logic [PW-1:0] vr_reg, vg_reg, vb_reg;
    logic [PW-1:0] yr_next, yg_next, yb_next;
    logic [PW-1:0] ur_next, ug_next, ub_next;
    logic [PW-1:0] vr_next, vg_next, vb_next;

    logic [LW-1:0]         y_sum;
    r2y_pkg::sample_t      luma_reg, luma_next;
    r2y_pkg::chroma_part_t u_part_reg, u_part_next;
    r2y_pkg::chroma_part_t v_part_reg, v_part_next;

    // Stage 1: each channel times each weight magnitude.
    always_comb
    begin
        yr_next = PW'(pixel.red)   * PW'(r2y_pkg::Y_R_COEF);
        yg_next = PW'(pixel.green) * PW'(r2y_pkg::Y_G_COEF);
        yb_next = PW'(pixel.blue)  * PW'(r2y_pkg::Y_B_COEF);
        ur_next = PW'(pixel.red)   * PW'(r2y_pkg::U_R_COEF);
        ug_next = PW'(pixel.green) * PW'(r2y_pkg::U_G_COEF);
        ub_next = PW'(pixel.blue)  * PW'(r2y_pkg::U_B_COEF);
        vr_next = PW'(pixel.red)   * PW'(r2y_pkg::V_R_COEF);
        vg_next = PW'(pixel.green) * PW'(r2y_pkg::V_G_COEF);
        vb_next = PW'(pixel.blue)  * PW'(r2y_pkg::V_B_COEF);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            yr_reg <= yr_next;
            yg_reg <= yg_next;
            yb_reg <= yb_next;
            ur_reg <= ur_next;
            ug_reg <= ug_next;
            ub_reg <= ub_next;
            vr_reg <= vr_next;
            vg_reg <= vg_next;
            vb_reg <= vb_next;
        end
    end

    // Stage 2: signed sums. Luma is rounded and clamped here; chroma keeps all
    // fraction bits and carries the 128 offset of this pixel.
    always_comb
    begin
        y_sum = LW'(yr_reg) + LW'(yg_reg) + LW'(yb_reg) + LW'(r2y_pkg::ROUND_HALF);
        if (y_sum[LW-1])
            luma_next = '1;
        else
            luma_next = y_sum[r2y_pkg::FRAC_W +: 8];
        u_part_next = CW'(r2y_pkg::CHROMA_BIAS) - CW'(ur_reg) - CW'(ug_reg) + CW'(ub_reg);
        v_part_next = CW'(r2y_pkg::CHROMA_BIAS) + CW'(vr_reg) - CW'(vg_reg) - CW'(vb_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            luma_reg   <= luma_next;
            u_part_reg <= u_part_next;
            v_part_reg <= v_part_next;
        end
    end

    assign luma   = luma_reg;
    assign u_part = u_part_reg;
    assign v_part = v_part_reg;

endmodule

@@ src/r2y_merge.sv @@
// Merging stage: sums the four lane chroma partials plus 32768, divides by 4 * 65536,
// clamps, and registers the finished output word. Uses r2y_pkg.
`timescale 1ns / 1ps

module r2y_merge (
    input  logic                  clk,
    input  logic                  en,
    input  r2y_pkg::sample_t      luma   [r2y_pkg::NUM_LANES],
    input  r2y_pkg::chroma_part_t u_part [r2y_pkg::NUM_LANES],
    input  r2y_pkg::chroma_part_t v_part [r2y_pkg::NUM_LANES],
    output r2y_pkg::yuv_word_t    word
);

    localparam int CW = r2y_pkg::PART_W;
    localparam int QW = CW - 1 - r2y_pkg::CHROMA_SHIFT;

    r2y_pkg::chroma_part_t u_sum, v_sum;
    r2y_pkg::yuv_word_t    word_reg, word_next;

    // Negative totals give zero; otherwise the quotient saturates at 255.
    function automatic r2y_pkg::sample_t clamp_chroma(input r2y_pkg::chroma_part_t total);
        logic [QW-1:0] q;
        q = total[CW-2:r2y_pkg::CHROMA_SHIFT];
        if (total[CW-1])
            return '0;
        else if (q > QW'(255))
            return '1;
        else
            return q[7:0];
    endfunction

    always_comb
    begin
        u_sum = CW'(r2y_pkg::ROUND_HALF) + u_part[0] + u_part[1] + u_part[2] + u_part[3];
        v_sum = CW'(r2y_pkg::ROUND_HALF) + v_part[0] + v_part[1] + v_part[2] + v_part[3];
        word_next.luma_tl  = luma[0];
        word_next.luma_tr  = luma[1];
        word_next.luma_bl  = luma[2];
        word_next.luma_br  = luma[3];
        word_next.chroma_u = clamp_chroma(u_sum);
        word_next.chroma_v = clamp_chroma(v_sum);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

@@ src/rgb24_to_yuv420_block.sv @@
// A word accepted at a clock edge is registered in the lane products, then the lane sums,
// then the merged output word, and takes longer only while the output is stalled.
// Throughput: one 2x2 block per cycle while the output is not stalled; each stage advances
// whenever the next one is empty or is moving, so bubbles close up under output stall.
// Reset: rst_n clears the three stage valid flags at once; data registers keep no reset.
`timescale 1ns / 1ps

module rgb24_to_yuv420_block (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pix_valid,
    output logic               pix_stall,
    input  r2y_pkg::pix_word_t pix_word,
    output logic               yuv_valid,
    input  logic               yuv_stall,
    output r2y_pkg::yuv_word_t yuv_word
);

    // Four identical lanes, one per pixel of the block. Each lane registers
    // nine constant products in its first stage and the luma plus two signed
    // chroma partials in its second stage. The merging stage adds the chroma
    // partials of all four lanes and registers the output word, which also
    // serves as the output holding register while the consumer stalls.

    r2y_pkg::rgb_t         pixel  [r2y_pkg::NUM_LANES];
    r2y_pkg::sample_t      luma   [r2y_pkg::NUM_LANES];
    r2y_pkg::chroma_part_t u_part [r2y_pkg::NUM_LANES];
    r2y_pkg::chroma_part_t v_part [r2y_pkg::NUM_LANES];

    r2y_pkg::stage_en_t lane_en;
    logic               merge_en;

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;

    // Lane order follows the output word: top left, top right, bottom left, bottom right.
    assign pixel[0] = '{red: pix_word.tl_red, green: pix_word.tl_green, blue: pix_word.tl_blue};
    assign pixel[1] = '{red: pix_word.tr_red, green: pix_word.tr_green, blue: pix_word.tr_blue};
    assign pixel[2] = '{red: pix_word.bl_red, green: pix_word.bl_green, blue: pix_word.bl_blue};
    assign pixel[3] = '{red: pix_word.br_red, green: pix_word.br_green, blue: pix_word.br_blue};

    // A stage may load when it is empty or when its contents move on in the same cycle.
    always_comb
    begin
        merge_en   = !out_valid_reg || !yuv_stall;
        lane_en.s2 = !s2_valid_reg || merge_en;
        lane_en.s1 = !s1_valid_reg || lane_en.s2;

        s1_valid_next  = lane_en.s1 ? pix_valid    : s1_valid_reg;
        s2_valid_next  = lane_en.s2 ? s1_valid_reg : s2_valid_reg;
        out_valid_next = merge_en   ? s2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    for (genvar i = 0; i < r2y_pkg::NUM_LANES; i++)
    begin : g_lane
        r2y_lane u_lane (
            .clk    (clk),
            .en     (lane_en),
            .pixel  (pixel[i]),
            .luma   (luma[i]),
            .u_part (u_part[i]),
            .v_part (v_part[i])
        );
    end

    r2y_merge u_merge (
        .clk    (clk),
        .en     (merge_en),
        .luma   (luma),
        .u_part (u_part),
        .v_part (v_part),
        .word   (yuv_word)
    );

    assign pix_stall = !lane_en.s1;
    assign yuv_valid = out_valid_reg;

`ifndef SYNTHESIS
    // The input is held off only when every stage is full and the output is stalled.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> (s1_valid_reg && s2_valid_reg && out_valid_reg && yuv_stall))
        else $error("input stalled while the pipeline has room");

    // A word in the first stage moves to the second when the input is not stalled.
    a_s1_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !pix_stall) |=> s2_valid_reg)
        else $error("word lost between lane stages");

    // A word in the second stage reaches the output register when that register is free.
    a_s2_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !(out_valid_reg && yuv_stall)) |=> out_valid_reg)
        else $error("word lost between lanes and merge");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the 2x2 RGB to YUV 4:2:0 block converter.
// It needs r2y_pkg and rgb24_to_yuv420_block. The expected words come from an
// internal fixed-point predictor, and for a few directed rows they are typed in.
`timescale 1ns / 1ps

module tb;

    // The luma weights sum to exactly 1.0 and the chroma weights to 0.0.
    // The signs are kept here instead of being applied in the adders.
    localparam longint Y_WR = 19595;
    localparam longint Y_WG = 38470;
    localparam longint Y_WB = 7471;
    localparam longint U_WR = -9634;
    localparam longint U_WG = -18940;
    localparam longint U_WB = 28574;
    localparam longint V_WR = 40305;
    localparam longint V_WG = -33751;
    localparam longint V_WB = -6554;
    localparam longint HALF_LSB   = 32768;
    localparam longint UV_OFFSET  = 128 * 65536;

    localparam int RANDOM_BLOCKS = 750;
    localparam int IDLE_PERCENT  = 23;
    // Both sides run without gaps for this range of block counts.
    localparam int CALM_FIRST    = 400;
    localparam int CALM_LAST     = 549;
    // After this many blocks, the output side holds off long enough to fill the pipe.
    localparam int HOLD_AFTER    = 200;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 8;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               pix_valid = 1'b0;
    logic               pix_stall;
    r2y_pkg::pix_word_t pix_word = '0;
    logic               yuv_valid;
    logic               yuv_stall = 1'b0;
    r2y_pkg::yuv_word_t yuv_word;

    // One row of the directed table. When typed is set, want holds the
    // hand-computed word. Otherwise the predictor supplies the word.
    typedef struct {
        r2y_pkg::pix_word_t pix;
        bit                 typed;
        r2y_pkg::yuv_word_t want;
    } block_case_t;

    block_case_t        directed_cases[$];
    r2y_pkg::yuv_word_t pending_yuv[$];
    int                 sent_count = 0;
    int                 checked_count = 0;
    int                 error_count = 0;
    bit                 hold_pending = 1'b0;
    int                 hold_left = 0;
    wire                calm = (sent_count >= CALM_FIRST) && (sent_count <= CALM_LAST);

    rgb24_to_yuv420_block DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_word  (pix_word),
        .yuv_valid (yuv_valid),
        .yuv_stall (yuv_stall),
        .yuv_word  (yuv_word)
    );

    always #5 clk = ~clk;

    // Reset is asserted once and is released on a clock edge.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // This is a flat fail-safe. Even the slowest legal run ends far sooner.
    initial
    begin
        #(5_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // A negative total saturates to 0. After the shift, anything above 255
    // saturates to 255.
    function automatic r2y_pkg::sample_t saturate_shift(longint total, int sh);
        longint q;
        if (total < 0)
            return 8'd0;
        q = total >>> sh;
        return (q > 255) ? 8'd255 : r2y_pkg::sample_t'(q);
    endfunction

    // Computes the luma of each pixel and the four-pixel chroma average, biased by 32768 as in the block.
    // All sums are held exactly with 16 fraction bits until the final shift.
    function automatic r2y_pkg::yuv_word_t convert_block(r2y_pkg::pix_word_t w);
        longint             r, g, b;
        longint             u_acc, v_acc;
        r2y_pkg::yuv_word_t o;
        u_acc = HALF_LSB;
        v_acc = HALF_LSB;
        for (int p = 0; p < 4; p++)
        begin
            r = longint'(w[95 - 24*p -: 8]);
            g = longint'(w[87 - 24*p -: 8]);
            b = longint'(w[79 - 24*p -: 8]);
            o[47 - 8*p -: 8] = saturate_shift(HALF_LSB + Y_WR*r + Y_WG*g + Y_WB*b, 16);
            u_acc += UV_OFFSET + U_WR*r + U_WG*g + U_WB*b;
            v_acc += UV_OFFSET + V_WR*r + V_WG*g + V_WB*b;
        end
        o.chroma_u = saturate_shift(u_acc, r2y_pkg::CHROMA_SHIFT);
        o.chroma_v = saturate_shift(v_acc, r2y_pkg::CHROMA_SHIFT);
        return o;
    endfunction

    function automatic r2y_pkg::pix_word_t solid(r2y_pkg::sample_t r, r2y_pkg::sample_t g,
                                                 r2y_pkg::sample_t b);
        return r2y_pkg::pix_word_t'({4{r, g, b}});
    endfunction

    // Offers one block word. The word may be preceded by random idle cycles.
    // The call returns on the edge at which the word is taken, and the
    // expected word is queued at that same edge. When no idle follows,
    // valid stays high into the next call.
    task automatic offer_block(r2y_pkg::pix_word_t w, bit typed, r2y_pkg::yuv_word_t want);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_word  <= w;
        do
            @(posedge clk);
        while (pix_stall);
        pending_yuv.push_back(typed ? want : convert_block(w));
        sent_count++;
        if (sent_count == HOLD_AFTER)
            hold_pending = 1'b1;
    endtask

    // Compares one accepted result word, field by field, with the oldest
    // expected word.
    task automatic check_yuv(r2y_pkg::yuv_word_t got);
        r2y_pkg::yuv_word_t want;
        string              names[6] = '{"luma_tl", "luma_tr", "luma_bl", "luma_br",
                                         "chroma_u", "chroma_v"};
        if (pending_yuv.size() == 0)
        begin
            $error("yuv word %h arrived with no block outstanding", got);
            error_count++;
            return;
        end
        want = pending_yuv.pop_front();
        checked_count++;
        for (int i = 0; i < 6; i++)
            if (got[47 - 8*i -: 8] !== want[47 - 8*i -: 8])
            begin
                $error("%s mismatch: expected %0d, actual %0d",
                       names[i], want[47 - 8*i -: 8], got[47 - 8*i -: 8]);
                error_count++;
            end
    endtask

    // This is the output side. Every value is read at the rising edge, before
    // that edge's updates take effect. The stall for the next cycle is then
    // chosen: a long hold once, then no stall in the calm stretch, and random
    // stalls elsewhere.
    always @(posedge clk)
    begin
        if (rst_n && yuv_valid && !yuv_stall)
            check_yuv(yuv_word);
        if (hold_left > 0)
        begin
            hold_left--;
            yuv_stall <= 1'b1;
        end
        else if (hold_pending)
        begin
            hold_pending = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            yuv_stall <= 1'b1;
        end
        else
            yuv_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end

    initial
    begin
        r2y_pkg::pix_word_t w;
        int                 mode;

        // Typed rows: black and white map to neutral chroma. Pure red pushes
        // V above 255, and cyan pushes V below 0.
        directed_cases.push_back('{solid(8'd0, 8'd0, 8'd0), 1'b1,
            '{8'd0, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128}});
        directed_cases.push_back('{solid(8'd255, 8'd255, 8'd255), 1'b1,
            '{8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128}});
        directed_cases.push_back('{solid(8'd255, 8'd0, 8'd0), 1'b1,
            '{8'd76, 8'd76, 8'd76, 8'd76, 8'd90, 8'd255}});
        directed_cases.push_back('{solid(8'd0, 8'd255, 8'd255), 1'b1,
            '{8'd179, 8'd179, 8'd179, 8'd179, 8'd165, 8'd0}});
        // The remaining primaries and secondaries, mid grey, and mixed blocks
        // are checked against the predictor.
        directed_cases.push_back('{solid(8'd0, 8'd255, 8'd0), 1'b0, '0});
        directed_cases.push_back('{solid(8'd0, 8'd0, 8'd255), 1'b0, '0});
        directed_cases.push_back('{solid(8'd255, 8'd0, 8'd255), 1'b0, '0});
        directed_cases.push_back('{solid(8'd255, 8'd255, 8'd0), 1'b0, '0});
        directed_cases.push_back('{solid(8'd128, 8'd128, 8'd128), 1'b0, '0});
        directed_cases.push_back('{r2y_pkg::pix_word_t'({24'hFF0000, 24'h00FF00, 24'h0000FF,
            24'hFFFFFF}), 1'b0, '0});
        directed_cases.push_back('{r2y_pkg::pix_word_t'({12{8'hAA}}), 1'b0, '0});
        directed_cases.push_back('{r2y_pkg::pix_word_t'({12{8'h55}}), 1'b0, '0});
        directed_cases.push_back('{r2y_pkg::pix_word_t'({24'hFFFFFF, 72'h0}), 1'b0, '0});
        directed_cases.push_back('{r2y_pkg::pix_word_t'({72'h0, 24'hFF0000}), 1'b0, '0});
        directed_cases.push_back('{r2y_pkg::pix_word_t'({24'h00FFFF, 24'h00FFFF, 24'hFF0000,
            24'hFF0000}), 1'b0, '0});

        @(posedge rst_n);
        @(posedge clk);

        foreach (directed_cases[i])
            offer_block(directed_cases[i].pix, directed_cases[i].typed,
                        directed_cases[i].want);

        // Most random blocks are uniform, which exercises every input bit.
        // The rest are saturated channels and colors that sit near the
        // clamp limits of V.
        for (int n = 0; n < RANDOM_BLOCKS; n++)
        begin
            mode = $urandom_range(9);
            w = r2y_pkg::pix_word_t'({$urandom, $urandom, $urandom});
            if (mode >= 6)
                for (int k = 0; k < 12; k++)
                begin
                    if (mode <= 7)
                        w[95 - 8*k -: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
                    else if ((mode == 8) == (k % 3 == 0))
                        w[95 - 8*k -: 8] = 8'($urandom_range(255, 200));
                    else
                        w[95 - 8*k -: 8] = 8'($urandom_range(40));
                end
            offer_block(w, 1'b0, '0);
        end
        pix_valid <= 1'b0;

        // Wait for the pipeline to drain. After that, allow a few more cycles
        // so that any extra output word can show up.
        while (pending_yuv.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d blocks (%0d directed), checked %0d result words.",
                 sent_count, directed_cases.size(), checked_count);
        $display("The run covered color extremes, V clamping both ways, random stalls and a long output hold.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
